/* sv/csfb_pkg.sv */
// ---------------------------------------------------------------------------
// csfb_pkg
// Shared widths, constants and controller/datapath command and status types
// for the counting sort unit.
// ---------------------------------------------------------------------------
package csfb_pkg;

	localparam int KEY_W         = 8;
	localparam int TAG_W         = 16;
	localparam int REC_W         = KEY_W + TAG_W;
	localparam int BIN_W         = 7;
	localparam int KEY_BINS      = 256;
	localparam int BIN_LAST      = KEY_BINS - 1;
	localparam int MAX_ITEMS_DEF = 64;

	typedef struct packed {
		logic accept;   // input word taken
		logic inc;      // bump bin count of latched key
		logic pfx_rd;   // prefix pass: read next bin
		logic pl_init;  // load placement index with record count
		logic pl_rd;    // read key/tag store
		logic pl_bin;   // read bin of the record's key
		logic pl_wr;    // place record, decrement bin
		logic em_rd;    // read placed store
		logic em_ld;    // load output register
		logic em_step;  // advance emit index
		logic clear;    // end of batch
	} csfb_cmd_t;

	typedef struct packed {
		logic full;
		logic pfx_end;
		logic idx_zero;
		logic empty;
		logic final_word;
	} csfb_sts_t;

endpackage

/* sv/csfb_ctrl.sv */
// ---------------------------------------------------------------------------
// csfb_ctrl
// Sequencer for load, prefix pass, stable placement and emit phases.
// ---------------------------------------------------------------------------
module csfb_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                last,
	output logic                out_valid,
	input  logic                out_ready,
	input  csfb_pkg::csfb_sts_t sts,
	output csfb_pkg::csfb_cmd_t cmd
);

	typedef enum logic [3:0] {
		IDLE,
		LOAD_INC,
		PREFIX,
		PFX_DRAIN,
		PL_RD,
		PL_BIN,
		PL_WR,
		EM_RD,
		EM_LD,
		EM_WAIT
	} state_t;

	state_t state_q;
	logic   in_ready_q;
	logic   out_valid_q;
	logic   last_q;

	assign in_ready  = in_ready_q;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		case (state_q)
			IDLE:      cmd.accept  = in_valid & in_ready_q;
			LOAD_INC:  cmd.inc     = 1'b1;
			PREFIX:    cmd.pfx_rd  = 1'b1;
			PFX_DRAIN: begin
				cmd.pl_init = 1'b1;
				cmd.clear   = sts.empty;
			end
			PL_RD:     cmd.pl_rd   = 1'b1;
			PL_BIN:    cmd.pl_bin  = 1'b1;
			PL_WR:     cmd.pl_wr   = 1'b1;
			EM_RD:     cmd.em_rd   = 1'b1;
			EM_LD:     cmd.em_ld   = 1'b1;
			EM_WAIT: begin
				cmd.clear   = out_ready & sts.final_word;
				cmd.em_step = out_ready & ~sts.final_word;
			end
			default:   cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			in_ready_q  <= 1'b1;
			out_valid_q <= 1'b0;
			last_q      <= 1'b0;
		end else begin
			case (state_q)
				IDLE: begin
					if (in_valid && in_ready_q) begin
						last_q <= last;
						if (!sts.full) begin
							state_q    <= LOAD_INC;
							in_ready_q <= 1'b0;
						end else if (last) begin
							// dropped word still closes the batch
							state_q    <= PREFIX;
							in_ready_q <= 1'b0;
						end
					end
				end
				LOAD_INC: begin
					if (last_q) begin
						state_q <= PREFIX;
					end else begin
						state_q    <= IDLE;
						in_ready_q <= 1'b1;
					end
				end
				PREFIX: begin
					if (sts.pfx_end)
						state_q <= PFX_DRAIN;
				end
				PFX_DRAIN: begin
					if (sts.empty) begin
						state_q    <= IDLE;
						in_ready_q <= 1'b1;
					end else begin
						state_q <= PL_RD;
					end
				end
				PL_RD:  state_q <= PL_BIN;
				PL_BIN: state_q <= PL_WR;
				PL_WR: begin
					state_q <= sts.idx_zero ? EM_RD : PL_RD;
				end
				EM_RD: state_q <= EM_LD;
				EM_LD: begin
					state_q     <= EM_WAIT;
					out_valid_q <= 1'b1;
				end
				EM_WAIT: begin
					if (out_ready) begin
						out_valid_q <= 1'b0;
						if (sts.final_word) begin
							state_q    <= IDLE;
							in_ready_q <= 1'b1;
						end else begin
							state_q <= EM_RD;
						end
					end
				end
				default: begin
					state_q     <= IDLE;
					in_ready_q  <= 1'b1;
					out_valid_q <= 1'b0;
				end
			endcase
		end
	end

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready_q && out_valid_q))
		else $error("input and output both open");

	a_valid_from_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == EM_LD))
		else $error("output valid raised outside emit load");

	a_place_to_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == PL_WR && sts.idx_zero) |=> state_q == EM_RD)
		else $error("placement did not hand over to emit");

endmodule

/* sv/csfb_datapath.sv */
// ---------------------------------------------------------------------------
// csfb_datapath
// Bin count memory with valid bits, key/tag stores, placed store, counters
// and the output register.
// ---------------------------------------------------------------------------
module csfb_datapath #(
	parameter int MAX_ITEMS = csfb_pkg::MAX_ITEMS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  csfb_pkg::csfb_cmd_t         cmd,
	output csfb_pkg::csfb_sts_t         sts,
	input  logic [csfb_pkg::KEY_W-1:0]  sort_key,
	input  logic [csfb_pkg::TAG_W-1:0]  record_tag,
	output logic [csfb_pkg::KEY_W-1:0]  sorted_key,
	output logic [csfb_pkg::TAG_W-1:0]  sorted_tag,
	output logic                        final_item,
	output logic                        overflowed
);

	localparam int CW = $clog2(MAX_ITEMS + 1);
	localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;

	// storage
	logic [csfb_pkg::BIN_W-1:0]    bin_mem    [csfb_pkg::KEY_BINS];
	logic [csfb_pkg::KEY_BINS-1:0] bin_vld_q;
	logic [csfb_pkg::KEY_W-1:0]    key_mem    [MAX_ITEMS];
	logic [csfb_pkg::TAG_W-1:0]    tag_mem    [MAX_ITEMS];
	logic [csfb_pkg::REC_W-1:0]    placed_mem [MAX_ITEMS];

	// control registers
	logic [CW-1:0]              count_q;
	logic                       drop_q;
	logic [CW-1:0]              idx_q;
	logic [csfb_pkg::KEY_W-1:0] pfx_idx_q;
	logic                       pfx_wr_s1;
	logic [csfb_pkg::BIN_W-1:0] acc_q;

	// payload registers
	logic [csfb_pkg::KEY_W-1:0] key_in_q;
	logic [csfb_pkg::KEY_W-1:0] pfx_addr_s1;
	logic [csfb_pkg::BIN_W-1:0] bin_rd_q;
	logic                       bin_hit_q;
	logic [csfb_pkg::KEY_W-1:0] key_rd_q;
	logic [csfb_pkg::TAG_W-1:0] tag_rd_q;
	logic [csfb_pkg::REC_W-1:0] placed_rd_q;
	logic [csfb_pkg::KEY_W-1:0] sorted_key_q;
	logic [csfb_pkg::TAG_W-1:0] sorted_tag_q;
	logic                       final_q;
	logic                       ovf_q;

	logic [csfb_pkg::BIN_W-1:0] bin_val;
	logic [csfb_pkg::BIN_W-1:0] acc_sum;
	logic [csfb_pkg::BIN_W-1:0] pos;
	logic [csfb_pkg::KEY_W-1:0] bin_raddr;
	logic                       bin_ren;
	logic                       bin_we;
	logic [csfb_pkg::KEY_W-1:0] bin_waddr;
	logic [csfb_pkg::BIN_W-1:0] bin_wdata;
	logic [CW-1:0]              idx_dec;
	logic [CW-1:0]              idx_inc;

	// a bin never written this batch reads as zero
	assign bin_val = bin_hit_q ? bin_rd_q : '0;
	assign acc_sum = acc_q + bin_val;
	assign pos     = bin_val - csfb_pkg::BIN_W'(1);
	assign idx_dec = idx_q - CW'(1);
	assign idx_inc = idx_q + CW'(1);

	assign bin_ren   = cmd.accept | cmd.pfx_rd | cmd.pl_bin;
	assign bin_raddr = cmd.accept ? sort_key : (cmd.pfx_rd ? pfx_idx_q : key_rd_q);

	always_comb begin
		bin_we    = 1'b0;
		bin_waddr = key_in_q;
		bin_wdata = bin_val + csfb_pkg::BIN_W'(1);
		if (cmd.inc) begin
			bin_we = 1'b1;
		end else if (pfx_wr_s1) begin
			bin_we    = 1'b1;
			bin_waddr = pfx_addr_s1;
			bin_wdata = acc_sum;
		end else if (cmd.pl_wr) begin
			bin_we    = 1'b1;
			bin_waddr = key_rd_q;
			bin_wdata = pos;
		end
	end

	always_ff @(posedge clk) begin
		if (bin_we)
			bin_mem[bin_waddr] <= bin_wdata;
		if (bin_ren) begin
			bin_rd_q  <= bin_mem[bin_raddr];
			bin_hit_q <= bin_vld_q[bin_raddr];
		end
		if (cmd.accept) begin
			key_in_q <= sort_key;
			if (!sts.full) begin
				key_mem[count_q[AW-1:0]] <= sort_key;
				tag_mem[count_q[AW-1:0]] <= record_tag;
			end
		end
		if (cmd.pl_rd) begin
			key_rd_q <= key_mem[idx_dec[AW-1:0]];
			tag_rd_q <= tag_mem[idx_dec[AW-1:0]];
		end
		if (cmd.pl_wr)
			placed_mem[pos[AW-1:0]] <= {key_rd_q, tag_rd_q};
		if (cmd.em_rd)
			placed_rd_q <= placed_mem[idx_q[AW-1:0]];
		if (cmd.em_ld) begin
			sorted_key_q <= placed_rd_q[csfb_pkg::REC_W-1:csfb_pkg::TAG_W];
			sorted_tag_q <= placed_rd_q[csfb_pkg::TAG_W-1:0];
			final_q      <= (idx_inc == count_q);
			ovf_q        <= drop_q;
		end
		pfx_addr_s1 <= pfx_idx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			drop_q    <= 1'b0;
			idx_q     <= '0;
			pfx_idx_q <= '0;
			pfx_wr_s1 <= 1'b0;
			acc_q     <= '0;
			bin_vld_q <= '0;
		end else begin
			pfx_wr_s1 <= cmd.pfx_rd;
			if (cmd.pfx_rd)
				pfx_idx_q <= pfx_idx_q + csfb_pkg::KEY_W'(1);
			if (cmd.clear) begin
				count_q   <= '0;
				drop_q    <= 1'b0;
				idx_q     <= '0;
				acc_q     <= '0;
				bin_vld_q <= '0;
			end else begin
				if (cmd.inc)
					count_q <= count_q + CW'(1);
				if (cmd.accept && sts.full)
					drop_q <= 1'b1;
				if (pfx_wr_s1)
					acc_q <= acc_sum;
				if (cmd.pl_init)
					idx_q <= count_q;
				else if (cmd.pl_rd)
					idx_q <= idx_dec;
				else if (cmd.em_step)
					idx_q <= idx_inc;
				if (bin_we)
					bin_vld_q[bin_waddr] <= 1'b1;
			end
		end
	end

	assign sts.full       = (count_q == CW'(MAX_ITEMS));
	assign sts.pfx_end    = (pfx_idx_q == csfb_pkg::KEY_W'(csfb_pkg::BIN_LAST));
	assign sts.idx_zero   = (idx_q == '0);
	assign sts.empty      = (count_q == '0);
	assign sts.final_word = final_q;

	assign sorted_key = sorted_key_q;
	assign sorted_tag = sorted_tag_q;
	assign final_item = final_q;
	assign overflowed = ovf_q;

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_ITEMS))
		else $error("record count above capacity");

	a_clear_batch: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear |=> (count_q == '0 && !drop_q && bin_vld_q == '0))
		else $error("batch state not cleared");

	a_place_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pl_wr |-> (bin_val != '0 && bin_val <= csfb_pkg::BIN_W'(MAX_ITEMS)))
		else $error("placement slot out of range");

	a_emit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.em_ld |-> idx_q < count_q)
		else $error("emit index past record count");

endmodule

/* sv/counting_sort_first_byte_unit.sv */
// ---------------------------------------------------------------------------
// counting_sort_first_byte_unit
// Stable counting sort of up to MAX_ITEMS records on an unsigned 8-bit key.
// ---------------------------------------------------------------------------
// Records are taken one word at a time; a stored record reads and writes
// back its bin in the count memory, a record past capacity is dropped. The
// word marked last closes the batch: a prefix pass runs over the 256-bin
// count memory, then stable placement handles each record in turn (store
// read, bin read, write), then each sorted word is read from the placed
// store, loaded into the output register and held until out_ready. No
// input is taken from the last word until the final sorted word is taken.
// final_item marks the last sorted word, overflowed is set on every word of
// a batch that dropped records. Bin counts clear at the end of each batch
// through their valid bits; there is no clearing pass.
module counting_sort_first_byte_unit #(
	parameter int MAX_ITEMS = csfb_pkg::MAX_ITEMS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [csfb_pkg::KEY_W-1:0] sort_key,
	input  logic [csfb_pkg::TAG_W-1:0] record_tag,
	input  logic                       last,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [csfb_pkg::KEY_W-1:0] sorted_key,
	output logic [csfb_pkg::TAG_W-1:0] sorted_tag,
	output logic                       final_item,
	output logic                       overflowed
);

	csfb_pkg::csfb_cmd_t cmd;
	csfb_pkg::csfb_sts_t sts;

	csfb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.last      (last),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	csfb_datapath #(
		.MAX_ITEMS (MAX_ITEMS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.sort_key   (sort_key),
		.record_tag (record_tag),
		.sorted_key (sorted_key),
		.sorted_tag (sorted_tag),
		.final_item (final_item),
		.overflowed (overflowed)
	);

endmodule

/* tb/sv/counting_sort_first_byte_unit_test.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// counting_sort_first_byte_unit_test
// Self-checking bench for the stable counting sort unit. Record words are
// pushed in batches closed by a word marked last. A behavioral sort keeps
// the expected sorted words per batch, and every sorted word taken from the
// unit is compared against them in order. Batches range from one record to
// past capacity, with random gaps and stalls on both sides.
// ---------------------------------------------------------------------------
module counting_sort_first_byte_unit_test;

	localparam int CAPACITY    = csfb_pkg::MAX_ITEMS_DEF;
	localparam int IDLE_LIMIT  = 3000;
	localparam int TAIL_CYCLES = 20;

	typedef struct {
		logic [csfb_pkg::KEY_W-1:0] key;
		logic [csfb_pkg::TAG_W-1:0] tag;
		logic                       last;
		int                         gap;    // idle cycles before this word
		bit                         drain;  // hold until all sorted words are out
	} rec_word_t;

	typedef struct {
		logic [csfb_pkg::KEY_W-1:0] key;
		logic [csfb_pkg::TAG_W-1:0] tag;
		logic                       fin;
		logic                       ovf;
	} sorted_word_t;

	typedef enum {KEYS_ANY, KEYS_CLUSTER, KEYS_EDGE} key_mix_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       in_valid = 1'b0;
	logic                       in_ready;
	logic [csfb_pkg::KEY_W-1:0] sort_key = '0;
	logic [csfb_pkg::TAG_W-1:0] record_tag = '0;
	logic                       last = 1'b0;
	logic                       out_valid;
	logic                       out_ready = 1'b0;
	logic [csfb_pkg::KEY_W-1:0] sorted_key;
	logic [csfb_pkg::TAG_W-1:0] sorted_tag;
	logic                       final_item;
	logic                       overflowed;

	rec_word_t                  send_q[$];
	rec_word_t                  next_word;
	sorted_word_t               sorted_due[$];
	logic [csfb_pkg::KEY_W-1:0] batch_keys[$];
	logic [csfb_pkg::TAG_W-1:0] batch_tags[$];
	bit                         batch_dropped = 1'b0;

	int fails = 0;
	int idle_cycles = 0;
	int gap_done = 0;
	int stall_left = 0;
	int cyc = 0;
	int total_words = 0;
	int accepted_words = 0;
	bit in_taken = 1'b0;

	counting_sort_first_byte_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.sort_key  (sort_key),
		.record_tag(record_tag),
		.last      (last),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sorted_key(sorted_key),
		.sorted_tag(sorted_tag),
		.final_item(final_item),
		.overflowed(overflowed)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [csfb_pkg::KEY_W-1:0] pick_key(key_mix_t mix,
		logic [csfb_pkg::KEY_W-1:0] base);
		case (mix)
			KEYS_CLUSTER: return base + csfb_pkg::KEY_W'($urandom_range(0, 3));
			KEYS_EDGE:    return $urandom_range(0, 1) ? 8'hFF : 8'h00;
			default:      return csfb_pkg::KEY_W'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic push_word(logic [csfb_pkg::KEY_W-1:0] key, logic [csfb_pkg::TAG_W-1:0] tag,
		logic lst);
		rec_word_t w;
		w.key = key;
		w.tag = tag;
		w.last = lst;
		w.gap = pick_gap();
		w.drain = 1'b0;
		send_q.push_back(w);
	endtask

	task automatic queue_batch(int n, key_mix_t mix, bit burst, bit drain);
		rec_word_t w;
		logic [csfb_pkg::KEY_W-1:0] base;
		base = csfb_pkg::KEY_W'($urandom_range(0, 255));
		for (int i = 0; i < n; i++) begin
			w.key = pick_key(mix, base);
			w.tag = csfb_pkg::TAG_W'($urandom_range(0, 65535));
			w.last = (i == n - 1);
			w.gap = burst ? 0 : pick_gap();
			w.drain = drain && (i == 0);
			send_q.push_back(w);
		end
	endtask

	// store the record (or drop it when full); on last, emit the batch stably sorted
	task automatic absorb_record(logic [csfb_pkg::KEY_W-1:0] key,
		logic [csfb_pkg::TAG_W-1:0] tag, logic lst);
		sorted_word_t s;
		int n;
		int placed;
		if (batch_keys.size() < CAPACITY) begin
			batch_keys.push_back(key);
			batch_tags.push_back(tag);
		end else begin
			batch_dropped = 1'b1;
		end
		if (lst) begin
			n = batch_keys.size();
			placed = 0;
			for (int k = 0; k < csfb_pkg::KEY_BINS; k++) begin
				for (int i = 0; i < n; i++) begin
					if (batch_keys[i] == k) begin
						s.key = batch_keys[i];
						s.tag = batch_tags[i];
						s.fin = (placed == n - 1);
						s.ovf = batch_dropped;
						sorted_due.push_back(s);
						placed++;
					end
				end
			end
			batch_keys.delete();
			batch_tags.delete();
			batch_dropped = 1'b0;
		end
	endtask

	task automatic compare_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
		if (exp_val !== act_val) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_val, act_val);
			fails++;
		end
	endtask

	task automatic check_sorted_word();
		sorted_word_t e;
		if (sorted_due.size() == 0) begin
			$display("%0t: unexpected sorted word, expected none, actual key %0h tag %0h",
				$time, sorted_key, sorted_tag);
			fails++;
		end else begin
			e = sorted_due.pop_front();
			compare_field("sorted_key", 32'(e.key), 32'(sorted_key));
			compare_field("sorted_tag", 32'(e.tag), 32'(sorted_tag));
			compare_field("final_item", 32'(e.fin), 32'(final_item));
			compare_field("overflowed", 32'(e.ovf), 32'(overflowed));
		end
	endtask

	// monitor: outputs first, then the incoming word
	always @(posedge clk) begin
		if (arst_n) begin
			cyc <= cyc + 1;
			in_taken <= in_valid && in_ready;
			if (out_valid && out_ready)
				check_sorted_word();
			if (in_valid && in_ready) begin
				absorb_record(sort_key, record_tag, last);
				accepted_words <= accepted_words + 1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// driver: a word stays up until taken
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_taken)) begin
			if (send_q.size() == 0) begin
				in_valid <= 1'b0;
			end else if (send_q[0].drain && sorted_due.size() != 0) begin
				in_valid <= 1'b0;
			end else if (gap_done < send_q[0].gap) begin
				in_valid <= 1'b0;
				gap_done <= gap_done + 1;
			end else begin
				next_word = send_q.pop_front();
				sort_key <= next_word.key;
				record_tag <= next_word.tag;
				last <= next_word.last;
				in_valid <= 1'b1;
				gap_done <= 0;
			end
		end
	end

	// receiver: stall-free windows alternate with random stalls
	always @(negedge clk) begin
		if (arst_n) begin
			if (cyc % 600 < 150) begin
				out_ready <= 1'b1;
			end else if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left <= stall_left - 1;
			end else begin
				out_ready <= 1'b1;
				if ($urandom_range(0, 3) == 0)
					stall_left <= pick_gap();
			end
		end
	end

	initial begin
		int oi;
		int n;

		// single-record batches at the key and tag extremes
		push_word(8'h00, 16'h0000, 1'b1);
		push_word(8'hFF, 16'hFFFF, 1'b1);
		// mixed keys with repeats: equal keys must keep arrival order
		push_word(8'hFF, 16'h0001, 1'b0);
		push_word(8'h00, 16'h0002, 1'b0);
		push_word(8'h80, 16'h5555, 1'b0);
		push_word(8'h00, 16'h0003, 1'b0);
		push_word(8'hFF, 16'hAAAA, 1'b0);
		push_word(8'h01, 16'h8000, 1'b1);
		// all keys equal
		push_word(8'h5A, 16'hA5A5, 1'b0);
		push_word(8'h5A, 16'h5A5A, 1'b0);
		push_word(8'h5A, 16'h0000, 1'b0);
		push_word(8'h5A, 16'hFFFF, 1'b1);
		// reverse order, then already sorted
		push_word(8'hFE, 16'h1234, 1'b0);
		push_word(8'h80, 16'h00FF, 1'b0);
		push_word(8'h7F, 16'hFF00, 1'b0);
		push_word(8'h01, 16'h4321, 1'b1);
		push_word(8'h10, 16'h0F0F, 1'b0);
		push_word(8'h20, 16'hF0F0, 1'b0);
		push_word(8'h30, 16'h7FFF, 1'b1);

		// random batches; one fills the store and then drops two words, the
		// second of them the word marked last
		oi = $urandom_range(0, 3);
		for (int b = 0; b < 4; b++) begin
			n = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
			// first random word waits for the directed batches to drain
			queue_batch(n, key_mix_t'($urandom_range(0, 2)), $urandom_range(0, 2) == 0, b == 0);
			if (b == oi)
				queue_batch(CAPACITY + 2, key_mix_t'($urandom_range(0, 2)),
					$urandom_range(0, 1) == 1, 1'b0);
		end
		total_words = send_q.size();

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (accepted_words < total_words || sorted_due.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);

		if (fails == 0 && sorted_due.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
